// ----- rtl/core/uhp_pkg.sv -----
`default_nettype none

package uhp_pkg;

  // Width of the per-frame byte counter; frames of 2**COUNT_BITS bytes or more are rejected
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Width that holds a frame length (count + 1) and header offset + UDP length
  localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  // Header offsets fit in 7 bits (at most 14 + 60 + 8)
  localparam int OFF_W = 7;

  localparam logic [1:0] LINK_ETH      = 2'd0;
  localparam logic [1:0] LINK_LOOPBACK = 2'd1;
  localparam logic [1:0] LINK_RAW_IP   = 2'd2;
  localparam logic [1:0] LINK_NONE     = 2'd3;

  localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]       PROTO_UDP      = 8'd17;
  localparam logic [3:0]       IP_VERSION4    = 4'd4;
  localparam logic [OFF_W-1:0] ETH_HDR        = 7'd14;
  localparam logic [OFF_W-1:0] LOOP_HDR       = 7'd4;
  localparam logic [OFF_W-1:0] IP_MIN         = 7'd20;
  localparam logic [OFF_W-1:0] UDP_HDR        = 7'd8;
  localparam logic [OFF_W-1:0] ETHERTYPE_POS  = 7'd12;
  localparam logic [OFF_W-1:0] PROTO_POS      = 7'd9;
  localparam logic [OFF_W-1:0] PORT_POS       = 7'd2;
  localparam logic [OFF_W-1:0] ULEN_POS       = 7'd4;

  function automatic logic [OFF_W-1:0] link_offset(input logic [1:0] link);
    logic [OFF_W-1:0] off;
    case (link)
      LINK_ETH:      off = ETH_HDR;
      LINK_LOOPBACK: off = LOOP_HDR;
      default:       off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/udp_ipv4_header_parser.sv -----
`default_nettype none

// Channel      Dir  Width  Contents
// s_axis       in   8+1    tdata[7:0] frame byte, tlast marks the final captured byte
// m_axis       out  40+1   tdata: dest_port, payload_offset, payload_length; tuser: accepted
// cfg_wr       in   2      link type (0 eth, 1 loopback, 2 raw ip, 3 reject all)
//
// One frame byte per cycle while a final byte finds the result register free. A byte is
// held in the input register, where a short compare-and-capture against the frame byte
// counter updates the header fields; the final byte also runs the checks and loads the
// result register. A held result stalls only a final byte: other bytes keep flowing past
// a stalled output. Synchronous reset clears the link type to Ethernet and all frame state.

module udp_ipv4_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  cfg_wr_data,   // link_type
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
  input  wire logic        s_axis_tlast,  // last_byte
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [15:0] dest_port, [22:16] payload_offset,
                                          // [38:23] payload_length, [39] zero
  output logic             m_axis_tuser,  // accepted
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);
  import uhp_pkg::*;

  // Configuration
  logic [1:0] link_type;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Frame state
  logic [COUNT_BITS-1:0] byte_index;
  logic                  too_long;
  logic [15:0]           ether_type;
  logic [7:0]            version_ihl;
  logic [7:0]            ip_protocol;
  logic [15:0]           port_seen;
  logic [15:0]           udp_length;

  logic [15:0] ether_type_next;
  logic [7:0]  version_ihl_next;
  logic [7:0]  ip_protocol_next;
  logic [15:0] port_seen_next;
  logic [15:0] udp_length_next;

  // Result register
  logic             out_valid;
  logic             out_accepted;
  logic [15:0]      out_port;
  logic [OFF_W-1:0] out_offset;
  logic [15:0]      out_length;

  logic             advance;
  logic             at_max;
  logic             cap;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] udp_off_cap;
  logic [OFF_W-1:0] udp_off_fin;
  logic [OFF_W-1:0] hdr_end;
  logic [SUM_W-1:0] len;
  logic [SUM_W-1:0] dgram_end;
  logic             ok;
  logic [15:0]      plen;

  // Advance the held byte unless it is a final byte facing a full result register
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  assign at_max = (byte_index == CNT_MAX);
  assign cap    = advance && !too_long && !at_max;
  assign off    = link_offset(link_type);

  // UDP field positions follow the IHL held before this byte
  assign udp_off_cap = off + {1'b0, version_ihl[3:0], 2'b00};

  always_comb begin
    ether_type_next  = ether_type;
    version_ihl_next = version_ihl;
    ip_protocol_next = ip_protocol;
    port_seen_next   = port_seen;
    udp_length_next  = udp_length;
    if (cap) begin
      if (byte_index == COUNT_BITS'(ETHERTYPE_POS)) begin
        ether_type_next[15:8] = in_byte;
      end
      if (byte_index == COUNT_BITS'(ETHERTYPE_POS + 7'd1)) begin
        ether_type_next[7:0] = in_byte;
      end
      if (byte_index == COUNT_BITS'(off)) begin
        version_ihl_next = in_byte;
      end
      if (byte_index == COUNT_BITS'(off + PROTO_POS)) begin
        ip_protocol_next = in_byte;
      end
      if (byte_index > COUNT_BITS'(off)) begin
        if (byte_index == COUNT_BITS'(udp_off_cap + PORT_POS)) begin
          port_seen_next[15:8] = in_byte;
        end
        if (byte_index == COUNT_BITS'(udp_off_cap + PORT_POS + 7'd1)) begin
          port_seen_next[7:0] = in_byte;
        end
        if (byte_index == COUNT_BITS'(udp_off_cap + ULEN_POS)) begin
          udp_length_next[15:8] = in_byte;
        end
        if (byte_index == COUNT_BITS'(udp_off_cap + ULEN_POS + 7'd1)) begin
          udp_length_next[7:0] = in_byte;
        end
      end
    end
  end

  // Final checks see the fields including the last byte
  assign len         = SUM_W'(byte_index) + SUM_W'(1);
  assign udp_off_fin = off + {1'b0, version_ihl_next[3:0], 2'b00};
  assign hdr_end     = udp_off_fin + UDP_HDR;
  assign dgram_end   = SUM_W'(udp_off_fin) + SUM_W'(udp_length_next);

  always_comb begin
    ok = !(too_long || at_max) && (link_type != LINK_NONE);
    if (link_type == LINK_ETH &&
        (len < SUM_W'(ETH_HDR) || ether_type_next != ETHERTYPE_IPV4)) begin
      ok = 1'b0;
    end
    if (len < SUM_W'(off + IP_MIN)) begin
      ok = 1'b0;
    end
    if (version_ihl_next[7:4] != IP_VERSION4) begin
      ok = 1'b0;
    end
    if (ip_protocol_next != PROTO_UDP) begin
      ok = 1'b0;
    end
    if (len < SUM_W'(hdr_end)) begin
      ok = 1'b0;
    end
    if (udp_length_next < 16'(UDP_HDR)) begin
      ok = 1'b0;
    end
  end

  // Clamp the payload to the captured bytes when the datagram runs past the capture
  always_comb begin
    if (dgram_end > len) begin
      plen = 16'(len - SUM_W'(hdr_end));
    end else begin
      plen = udp_length_next - 16'(UDP_HDR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= LINK_ETH;
    end else if (cfg_wr_en) begin
      link_type <= cfg_wr_data;
    end
  end

  // Input register: load a beat whenever the stage is free or moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      too_long    <= 1'b0;
      ether_type  <= '0;
      version_ihl <= '0;
      ip_protocol <= '0;
      port_seen   <= '0;
      udp_length  <= '0;
    end else if (advance) begin
      if (in_last) begin
        // Drop all frame state for the next frame
        byte_index  <= '0;
        too_long    <= 1'b0;
        ether_type  <= '0;
        version_ihl <= '0;
        ip_protocol <= '0;
        port_seen   <= '0;
        udp_length  <= '0;
      end else begin
        if (cap) begin
          byte_index <= byte_index + COUNT_BITS'(1);
        end
        if (!too_long && at_max) begin
          too_long <= 1'b1;
        end
        ether_type  <= ether_type_next;
        version_ihl <= version_ihl_next;
        ip_protocol <= ip_protocol_next;
        port_seen   <= port_seen_next;
        udp_length  <= udp_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_accepted <= ok;
      out_port     <= ok ? port_seen_next : 16'd0;
      out_offset   <= ok ? hdr_end : '0;
      out_length   <= ok ? plen : 16'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_accepted;
  assign m_axis_tdata  = {1'b0, out_length, out_offset, out_port};

  // A final beat always leaves the frame state clean
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> byte_index == '0 && !too_long && version_ihl == '0)
    else $error("frame state not cleared after final beat");

  // An overlong frame has its counter pinned at the top
  a_too_long_at_max: assert property (@(posedge clk) disable iff (rst)
    too_long |-> at_max)
    else $error("too_long set below counter maximum");

  // A stalled final beat holds in the input register
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled input beat lost");

  // An accepted result points past a full UDP header, a rejected one is all zero
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_accepted && out_offset >= UDP_HDR + IP_MIN - IP_MIN) ||
                  (!out_accepted && out_offset == '0 && out_port == 16'd0 &&
                   out_length == 16'd0))
    else $error("inconsistent result beat");

  // A result is never dropped while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire
